/* hdl/mmed_pkg.sv */
// Package for the multichannel moving median filter.
// Holds widths, default sizes, controller states and the command/status types.
// No dependencies.
`timescale 1ns / 1ps

package mmed_pkg;

    localparam int CHANNELS_DEF   = 2;
    localparam int MAX_WINDOW_DEF = 10;
    localparam int SAMPLE_W       = 16;
    localparam int LEN_W          = 4;
    localparam logic [LEN_W-1:0] WINDOW_LEN_RST = 4'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_LOAD,
        ST_SORT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_CAPTURE,
        OP_WRITE,
        OP_LOAD,
        OP_SORT,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic load_last;
        logic sort_last;
        logic bad;
        logic out_busy;
    } dp_status_t;

endpackage

/* hdl/multichannel_moving_median_top.sv */
// An accepted word is written to the ring RAM, its channel's window is loaded
// (one entry a cycle) and odd-even sorted (one phase a cycle), and the median is
// emitted; the input stalls meanwhile. An out-of-range word skips to a zero median.
// Reset: window_len returns to 5, pointers clear, then a clearing pass over all
// CHANNELS*MAX_WINDOW entries zeroes the ring RAM with the input stalled.
// Depends on mmed_pkg, mmed_ctrl, mmed_dp, mmed_ram.
`timescale 1ns / 1ps

module multichannel_moving_median_top #(
    parameter int CHANNELS   = mmed_pkg::CHANNELS_DEF,
    parameter int MAX_WINDOW = mmed_pkg::MAX_WINDOW_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mmed_pkg::LEN_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 channel,
    input  logic signed [mmed_pkg::SAMPLE_W-1:0] sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [mmed_pkg::SAMPLE_W-1:0] median
);

    import mmed_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mmed_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mmed_dp #(
        .CHANNELS   (CHANNELS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .channel   (channel),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .median    (median),
        .cmd       (cmd),
        .status    (status)
    );

    a_accept_captures: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (cmd.op == OP_CAPTURE))
        else $error("input word accepted without capture");

    a_emit_not_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) |-> !(out_valid && out_stall))
        else $error("emit would overwrite a waiting word");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) |=> out_valid)
        else $error("emitted word not presented");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD || cmd.op == OP_SORT || cmd.op == OP_CLEAR) |-> in_stall)
        else $error("input open while a word is in progress");

endmodule

/* hdl/mmed_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module mmed_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/mmed_ctrl.sv */
// Controller state machine: clearing pass, accept, write, load, sort, emit.
// Depends on mmed_pkg.
`timescale 1ns / 1ps

module mmed_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mmed_pkg::dp_status_t status,
    output mmed_pkg::dp_cmd_t    cmd
);

    import mmed_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_stall   = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (status.bad)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = OP_WRITE;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.op = OP_LOAD;
                if (status.load_last)
                begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                cmd.op = OP_SORT;
                if (status.sort_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

/* hdl/mmed_dp.sv */
// Datapath: window length register, write pointers, ring RAM, window
// registers with odd-even compare-exchange cells, and the output register.
// Depends on mmed_pkg and mmed_ram.
`timescale 1ns / 1ps

module mmed_dp #(
    parameter int CHANNELS   = mmed_pkg::CHANNELS_DEF,
    parameter int MAX_WINDOW = mmed_pkg::MAX_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mmed_pkg::LEN_W-1:0]          cfg_data,
    input  logic                                channel,
    input  logic signed [mmed_pkg::SAMPLE_W-1:0] sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mmed_pkg::SAMPLE_W-1:0] median,
    input  mmed_pkg::dp_cmd_t                   cmd,
    output mmed_pkg::dp_status_t                status
);

    import mmed_pkg::*;

    localparam int DEPTH    = CHANNELS * MAX_WINDOW;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int IDX_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [LEN_W-1:0]           window_len_reg;
    logic [LEN_W-1:0]           ptr_reg [CHANNELS];
    logic [LEN_W-1:0]           ptr_next [CHANNELS];
    logic                       ch_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       bad_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic signed [SAMPLE_W-1:0] win_reg [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] win_next [MAX_WINDOW];
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] median_reg;
    logic signed [SAMPLE_W-1:0] median_next;

    logic [CH_IDX_W-1:0]        ch_idx;
    logic [LEN_W-1:0]           ptr_cur;
    logic [LEN_W:0]             ptr_inc;
    logic [LEN_W-1:0]           ptr_new;
    logic [CNT_W-1:0]           len_c;
    logic [CNT_W-1:0]           cnt_m1;
    logic [ADDR_W-1:0]          base;
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [SAMPLE_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic [IDX_W+LEN_W-1:0]     mid_wide;
    logic [IDX_W-1:0]           mid;
    logic                       bad_now;

    assign cfg_ready = 1'b1;

    assign ch_idx  = CH_IDX_W'(ch_reg);
    assign ptr_cur = ptr_reg[ch_idx];
    assign ptr_inc = {1'b0, ptr_cur} + (LEN_W+1)'(1);
    assign ptr_new = (ptr_inc >= {1'b0, window_len_reg}) ? '0 : ptr_inc[LEN_W-1:0];
    assign len_c   = CNT_W'(window_len_reg);
    assign cnt_m1  = cnt_reg - CNT_W'(1);
    assign base    = ch_reg ? ADDR_W'(MAX_WINDOW) : '0;
    assign mid_wide = {{IDX_W{1'b0}}, window_len_reg >> 1};
    assign mid      = mid_wide[IDX_W-1:0];
    assign bad_now  = (window_len_reg == '0) || (int'(window_len_reg) > MAX_WINDOW)
                      || (int'(channel) >= CHANNELS);

    assign status.clr_last  = (cnt_reg == CNT_W'(DEPTH - 1));
    assign status.load_last = (cnt_reg == len_c);
    assign status.sort_last = (cnt_reg == cnt_m1 + CNT_W'(1)) && (cnt_reg == len_c - CNT_W'(1));
    assign status.bad       = bad_reg;
    assign status.out_busy  = out_valid_reg && out_stall;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(cnt_reg);
        ram_wdata = '0;
        case (cmd.op)
            OP_CLEAR:
            begin
                ram_we = 1'b1;
            end
            OP_WRITE:
            begin
                ram_we    = !bad_reg;
                ram_waddr = base + ADDR_W'(ptr_new);
                ram_wdata = sample_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_raddr = base + ADDR_W'(cnt_reg);

    mmed_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        case (cmd.op)
            OP_CLEAR: cnt_next = status.clr_last ? '0 : cnt_reg + CNT_W'(1);
            OP_LOAD:  cnt_next = status.load_last ? '0 : cnt_reg + CNT_W'(1);
            OP_SORT:  cnt_next = status.sort_last ? '0 : cnt_reg + CNT_W'(1);
            default:  cnt_next = '0;
        endcase
    end

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            ptr_next[c] = ptr_reg[c];
        end
        if ((cmd.op == OP_WRITE) && !bad_reg)
        begin
            ptr_next[ch_idx] = ptr_new;
        end
    end

    always_comb
    begin
        logic swap [MAX_WINDOW];
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            swap[k] = 1'b0;
        end
        for (int k = 0; k + 1 < MAX_WINDOW; k++)
        begin
            swap[k] = ((k % 2) == int'(cnt_reg[0])) && ((k + 1) < int'(window_len_reg))
                      && (win_reg[k] > win_reg[k + 1]);
        end
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            win_next[k] = win_reg[k];
            if ((cmd.op == OP_LOAD) && (cnt_reg != '0) && (cnt_m1 == CNT_W'(k)))
            begin
                win_next[k] = $signed(ram_rdata);
            end
            else if (cmd.op == OP_SORT)
            begin
                if (swap[k])
                begin
                    win_next[k] = win_reg[(k + 1) % MAX_WINDOW];
                end
                else if ((k > 0) && swap[(k + MAX_WINDOW - 1) % MAX_WINDOW])
                begin
                    win_next[k] = win_reg[(k + MAX_WINDOW - 1) % MAX_WINDOW];
                end
            end
        end
    end

    always_comb
    begin
        median_next    = median_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.op == OP_EMIT)
        begin
            out_valid_next = 1'b1;
            median_next    = bad_reg ? '0 : win_reg[mid];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_RST;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                ptr_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                window_len_reg <= cfg_data;
            end
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            for (int c = 0; c < CHANNELS; c++)
            begin
                ptr_reg[c] <= ptr_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CAPTURE)
        begin
            ch_reg     <= channel;
            sample_reg <= sample;
            bad_reg    <= bad_now;
        end
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            win_reg[k] <= win_next[k];
        end
        median_reg <= median_next;
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;

endmodule
